// ----- rtl/core/base85_encoder_unit_defines.svh -----
// assertion macros for the base85 encoder
`ifndef BASE85_ENCODER_UNIT_DEFINES_SVH
`define BASE85_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define B85_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define B85_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define B85_ASSERT(lbl, prop, msg)
`define B85_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/b85enc_pkg.sv -----
// types, constants and the z85 alphabet shared by the base85 encoder
`timescale 1ns / 1ps
package b85enc_pkg;

  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned NUM_DIGITS  = 5;
  localparam int unsigned DIG_W       = 7;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned PROD_W      = 2 * WORD_W;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_Z85_VARIANT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACE_EN    = 8'd1;

  localparam logic [WORD_W-1:0] SPACE_WORD   = 32'h2020_2020;
  // ceil(2^38 / 85): exact quotient for every 32-bit dividend
  localparam logic [WORD_W-1:0] RECIP_85     = 32'hC0C0_C0C1;
  localparam logic [WORD_W-1:0] RADIX        = 32'd85;
  localparam logic [7:0]        A85_OFFSET   = 8'd33;
  localparam logic [7:0]        CHAR_ZERO    = 8'h7A;
  localparam logic [7:0]        CHAR_SPACE   = 8'h79;

  localparam logic [8*85-1:0] Z85_ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  typedef enum logic [1:0] {
    KIND_DIGITS,
    KIND_ZERO,
    KIND_SPACE,
    KIND_ERROR
  } job_kind_e;

  typedef struct packed {
    logic z85_variant;
    logic space_en;
  } cfg_t;

  typedef struct packed {
    job_kind_e  kind;
    logic [2:0] nchars;
    logic       z85;
    logic       last;
  } job_meta_t;

  typedef struct packed {
    job_meta_t         meta;
    logic [WORD_W-1:0] word;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
    logic       stream_end;
    logic       length_error;
  } out_item_t;

  function automatic logic [7:0] z85_char(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    c = 8'h00;
    if (d < DIG_W'(85)) begin
      c = Z85_ALPHABET[8 * (84 - int'(d)) +: 8];
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/b85enc_front.sv -----
// front end: packs bytes into groups and classifies finished groups into jobs
`timescale 1ns / 1ps
module b85enc_front
  import b85enc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_data_i,
  input  logic       s_last_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [WORD_W-1:0] group_q, group_d;
  logic [1:0]        count_q, count_d;
  logic [WORD_W-1:0] word;
  logic              accept;
  logic              full_group;

  assign s_ready_o  = !q_status_i.full;
  assign accept     = s_valid_i && s_ready_o;
  assign full_group = (count_q == 2'd3);

  always_comb begin
    unique case (count_q)
      2'd0: word = group_q | {s_data_i, 24'h0};
      2'd1: word = group_q | {8'h0, s_data_i, 16'h0};
      2'd2: word = group_q | {16'h0, s_data_i, 8'h0};
      2'd3: word = group_q | {24'h0, s_data_i};
      default: word = group_q;
    endcase
  end

  always_comb begin
    job_o.word        = word;
    job_o.meta.z85    = cfg_i.z85_variant;
    job_o.meta.last   = s_last_i;
    job_o.meta.kind   = KIND_DIGITS;
    job_o.meta.nchars = 3'd5;
    if (full_group) begin
      if (!cfg_i.z85_variant && word == '0) begin
        job_o.meta.kind   = KIND_ZERO;
        job_o.meta.nchars = 3'd1;
      end else if (!cfg_i.z85_variant && cfg_i.space_en && word == SPACE_WORD) begin
        job_o.meta.kind   = KIND_SPACE;
        job_o.meta.nchars = 3'd1;
      end
    end else if (cfg_i.z85_variant) begin
      job_o.meta.kind   = KIND_ERROR;
      job_o.meta.nchars = 3'd1;
    end else begin
      // padded partial group gives one more char than its bytes, the closing byte included
      job_o.meta.nchars = {1'b0, count_q} + 3'd2;
    end
  end

  assign push_o = accept && (full_group || s_last_i);

  always_comb begin
    group_d = group_q;
    count_d = count_q;
    if (accept) begin
      if (full_group || s_last_i) begin
        group_d = '0;
        count_d = 2'd0;
      end else begin
        group_d = word;
        count_d = count_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      count_q <= 2'd0;
    end else begin
      group_q <= group_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- rtl/core/b85enc_queue.sv -----
// short job queue between the front end and the digit back end
`timescale 1ns / 1ps
module b85enc_queue
  import b85enc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign job_o          = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/b85enc_back.sv -----
// back end: base-85 digit pipeline, char serializer and output register
`timescale 1ns / 1ps
module b85enc_back
  import b85enc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  input  job_t      job_i,
  output logic      pop_o,
  output logic      m_valid_o,
  input  logic      m_ready_i,
  output out_item_t m_item_o
);

  // stage 0 holds the word and its first product, stages 1..4 peel one digit each
  localparam int unsigned STAGES = NUM_DIGITS;

  logic              vld_q  [STAGES];
  job_meta_t         meta_q [STAGES];
  logic [WORD_W-1:0] x_q    [STAGES-1];
  logic [PROD_W-1:0] p_q    [STAGES-1];
  logic [DIG_W-1:0]  dig_q  [1:STAGES-1][NUM_DIGITS];

  logic [QUOT_W-1:0] quot_w [1:STAGES-1];
  logic [DIG_W-1:0]  rem_w  [1:STAGES-1];

  logic [2:0]        idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q;
  out_item_t         cur_item;
  logic [DIG_W-1:0]  cur_digit;
  logic              out_load;
  logic              cur_done;
  logic              adv;

  always_comb begin
    for (int s = 1; s < STAGES; s++) begin
      quot_w[s] = p_q[s-1][PROD_W-1:RECIP_SHIFT];
      rem_w[s]  = DIG_W'(x_q[s-1] - WORD_W'(quot_w[s]) * RADIX);
    end
  end

  // the last stage is the serializer source, idx_q walks its chars
  assign cur_digit = dig_q[STAGES-1][idx_q];

  always_comb begin
    cur_item.run_last     = (idx_q == meta_q[STAGES-1].nchars - 3'd1);
    cur_item.stream_end   = cur_item.run_last && meta_q[STAGES-1].last;
    cur_item.length_error = 1'b0;
    unique case (meta_q[STAGES-1].kind)
      KIND_DIGITS: begin
        if (meta_q[STAGES-1].z85) begin
          cur_item.out_char = z85_char(cur_digit);
        end else begin
          cur_item.out_char = {1'b0, cur_digit} + A85_OFFSET;
        end
      end
      KIND_ZERO:  cur_item.out_char = CHAR_ZERO;
      KIND_SPACE: cur_item.out_char = CHAR_SPACE;
      KIND_ERROR: begin
        cur_item.out_char     = 8'h00;
        cur_item.length_error = 1'b1;
      end
      default: cur_item.out_char = 8'h00;
    endcase
  end

  assign out_load = vld_q[STAGES-1] && (!out_valid_q || m_ready_i);
  assign cur_done = out_load && cur_item.run_last;
  assign adv      = !vld_q[STAGES-1] || cur_done;
  assign pop_o    = adv && q_valid_i;

  always_comb begin
    idx_d = idx_q;
    if (cur_done) begin
      idx_d = 3'd0;
    end else if (out_load) begin
      idx_d = idx_q + 3'd1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < STAGES; s++) begin
        vld_q[s] <= 1'b0;
      end
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        vld_q[0] <= q_valid_i;
        for (int s = 1; s < STAGES; s++) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= job_i.meta;
      x_q[0]    <= job_i.word;
      p_q[0]    <= {{WORD_W{1'b0}}, job_i.word} * {{WORD_W{1'b0}}, RECIP_85};
      for (int s = 1; s < STAGES; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
      for (int s = 1; s < STAGES - 1; s++) begin
        x_q[s] <= WORD_W'(quot_w[s]);
        p_q[s] <= {{WORD_W{1'b0}}, WORD_W'(quot_w[s])} * {{WORD_W{1'b0}}, RECIP_85};
      end
      for (int d = 0; d < NUM_DIGITS; d++) begin
        dig_q[1][d] <= (d == NUM_DIGITS - 1) ? rem_w[1] : '0;
      end
      for (int s = 2; s < STAGES; s++) begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
          if (d == NUM_DIGITS - s) begin
            dig_q[s][d] <= rem_w[s];
          end else if (s == STAGES - 1 && d == 0) begin
            // what is left after four divisions is the leading digit
            dig_q[s][d] <= DIG_W'(quot_w[s]);
          end else begin
            dig_q[s][d] <= dig_q[s-1][d];
          end
        end
      end
    end
    if (out_load) begin
      out_item_q <= cur_item;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_item_o  = out_item_q;

endmodule

// ----- rtl/core/base85_encoder_unit.sv -----
// Streaming Ascii85 / Z85 encoder. One byte is taken per cycle while the job queue has
// room; every fourth byte (or the last byte of a stream) becomes a job that runs through a
// five-stage base-85 digit pipeline and is then sent out one char per cycle while the output
// is not stalled. A full group gives 5 chars, the 'z' and 'y' shortcuts and the Z85 length
// error give 1, and a padded partial group gives count+1. Sustained throughput on plain data
// is set by the one-char-per-cycle serializer, on shortcut groups by the byte input. A byte
// that closes a group goes through the job queue, the digit stages and the output register.
// Configuration writes are always ready and apply from the next group to close.
`timescale 1ns / 1ps
`include "base85_encoder_unit_defines.svh"
module base85_encoder_unit
  import b85enc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_char
  output logic                 m_axis_tlast,
  output logic [1:0]           m_axis_tuser,   // [0] stream_end, [1] length_error
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  q_status_t q_status;
  job_t      front_job;
  job_t      queue_job;
  logic      front_push;
  logic      back_pop;
  out_item_t out_item;
  logic      err_item;
  logic      err_item_ok;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_Z85_VARIANT: cfg_d.z85_variant = cfg_data_i;
        REG_SPACE_EN:    cfg_d.space_en    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  b85enc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .s_data_i   (s_axis_tdata),
    .s_last_i   (s_axis_tlast),
    .q_status_i (q_status),
    .push_o     (front_push),
    .job_o      (front_job)
  );

  b85enc_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (front_push),
    .job_i    (front_job),
    .pop_i    (back_pop),
    .job_o    (queue_job),
    .status_o (q_status)
  );

  b85enc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (!q_status.empty),
    .job_i     (queue_job),
    .pop_o     (back_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_item_o  (out_item)
  );

  assign m_axis_tdata = out_item.out_char;
  assign m_axis_tlast = out_item.run_last;
  assign m_axis_tuser = {out_item.length_error, out_item.stream_end};

  assign err_item    = m_axis_tvalid && m_axis_tuser[1];
  assign err_item_ok = m_axis_tlast && m_axis_tuser[0] && (m_axis_tdata == 8'h00);

  `B85_ASSERT_NEVER(a_queue_overflow, front_push && q_status.full, "job pushed into full queue")
  `B85_ASSERT_NEVER(a_queue_underflow, back_pop && q_status.empty, "job popped from empty queue")
  `B85_ASSERT(a_error_item, err_item |-> err_item_ok, "malformed length error item")
  `B85_ASSERT(a_end_is_last, (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast, "stream end without run last")

endmodule

// ----- test/base85_encoder_unit_tb.sv -----
// self-checking testbench for the streaming ascii85 / z85 encoder
`timescale 1ns / 1ps
module base85_encoder_unit_tb;
  import b85enc_pkg::CFG_IDX_W;
  import b85enc_pkg::REG_Z85_VARIANT;
  import b85enc_pkg::REG_SPACE_EN;

  localparam int unsigned   LIMIT_CYCLES  = 200000;
  localparam int unsigned   SETTLE_CYCLES = 32;
  localparam int unsigned   BASE          = 85;
  localparam logic [7:0]    A85_BIAS      = 8'd33;
  localparam logic [7:0]    CH_ZERO_WORD  = "z";
  localparam logic [7:0]    CH_SPACE_WORD = "y";
  localparam logic [31:0]   SPACE_PATTERN = 32'h2020_2020;
  localparam logic [8*85-1:0] Z85_SET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       stream_end;
    logic       len_err;
  } b85_char_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = 8'h00;  // [7:0] data_byte
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;           // [7:0] out_char
  logic                 m_axis_tlast;
  logic [1:0]           m_axis_tuser;           // [0] stream_end, [1] length_error
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic                 cfg_data_i    = 1'b0;

  byte_item_t  pending_bytes[$];
  b85_char_t   exp_chars[$];
  int unsigned idle_pct    = 30;
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  // encoder image kept by the testbench
  logic        cfg_z85   = 1'b0;
  logic        cfg_space = 1'b0;
  logic [31:0] grp_word  = '0;
  int unsigned grp_count = 0;

  base85_encoder_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] digit_char(input logic [7:0] d, input logic z85);
    if (z85) begin
      return Z85_SET[8 * (84 - int'(d)) +: 8];
    end
    return d + A85_BIAS;
  endfunction

  // fold one accepted byte into the group and queue the chars it produces
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [31:0] word;
    logic [31:0] rem;
    logic [7:0]  dig[5];
    logic [7:0]  chars[5];
    logic        err;
    int unsigned n;
    int          cnt;
    int          j;
    b85_char_t   r;
    n    = grp_count + 1;
    word = grp_word | (32'(b) << (8 * (4 - n)));
    rem  = word;
    for (j = 4; j >= 0; j--) begin
      dig[j] = 8'(rem % BASE);
      rem    = rem / BASE;
    end
    cnt = 0;
    err = 1'b0;
    if (n == 4) begin
      if (!cfg_z85 && word == '0) begin
        chars[0] = CH_ZERO_WORD;
        cnt = 1;
      end else if (!cfg_z85 && cfg_space && word == SPACE_PATTERN) begin
        chars[0] = CH_SPACE_WORD;
        cnt = 1;
      end else begin
        for (j = 0; j < 5; j++) chars[j] = digit_char(dig[j], cfg_z85);
        cnt = 5;
      end
    end else if (last) begin
      if (cfg_z85) begin
        chars[0] = 8'h00;
        err = 1'b1;
        cnt = 1;
      end else begin
        // padded partial group, no shortcuts
        for (j = 0; j <= int'(n); j++) chars[j] = digit_char(dig[j], 1'b0);
        cnt = n + 1;
      end
    end
    if (n == 4 || last) begin
      grp_word  = '0;
      grp_count = 0;
    end else begin
      grp_word  = word;
      grp_count = n;
    end
    for (j = 0; j < cnt; j++) begin
      r.ch         = chars[j];
      r.run_last   = (j == cnt - 1);
      r.stream_end = last && (j == cnt - 1);
      r.len_err    = err;
      exp_chars.push_back(r);
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin : drv_blk
    byte_item_t nxt;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        encode_byte(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
          nxt = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.data;
          s_axis_tlast  <= nxt.last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // char monitor
  always @(posedge clk_i) begin : mon_blk
    b85_char_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (exp_chars.size() == 0) begin
          $display("%0t: unexpected char, expected none, actual %h last %b user %b",
                   $time, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          fail_count++;
        end else begin
          want = exp_chars.pop_front();
          check_field("out_char", want.ch, m_axis_tdata);
          check_field("run_last", 8'(want.run_last), 8'(m_axis_tlast));
          check_field("stream_end", 8'(want.stream_end), 8'(m_axis_tuser[0]));
          check_field("length_error", 8'(want.len_err), 8'(m_axis_tuser[1]));
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // wait until the sender is empty and every char has come out
  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (exp_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_Z85_VARIANT) begin
      cfg_z85 = val;
    end else if (idx == REG_SPACE_EN) begin
      cfg_space = val;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_byte(input logic [7:0] d, input logic last);
    byte_item_t it;
    it.data = d;
    it.last = last;
    pending_bytes.push_back(it);
  endtask

  // each group picks a pattern so that shortcuts and the top word show up often
  task automatic queue_stream(input int nbytes);
    int k;
    int pat;
    logic [7:0] d;
    pat = 0;
    for (k = 0; k < nbytes; k++) begin
      if (k % 4 == 0) pat = $urandom_range(9, 0);
      case (pat)
        0:       d = 8'h00;
        1:       d = SPACE_PATTERN[7:0];
        2:       d = 8'hFF;
        default: d = 8'($urandom_range(255, 0));
      endcase
      push_byte(d, k == nbytes - 1);
    end
  endtask

  task automatic run_phase(input logic z85, input logic space, input int unsigned pct,
                           input int nitems);
    int n;
    int len;
    drain();
    write_reg(REG_Z85_VARIANT, z85);
    write_reg(REG_SPACE_EN, space);
    idle_pct = pct;
    n = 0;
    while (n < nitems) begin
      // mostly whole groups, now and then a ragged tail
      len = 4 * $urandom_range(3, 0);
      if ($urandom_range(3, 0) == 0) len += $urandom_range(3, 1);
      if (len == 0) len = 4;
      queue_stream(len);
      n += len;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // ascii85 after reset: zero word, top word, padded tails
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b1);
    drain();
    write_reg(REG_SPACE_EN, 1'b1);
    push_byte(8'h20, 1'b0); push_byte(8'h20, 1'b0);
    push_byte(8'h20, 1'b0); push_byte(8'h20, 1'b1);
    drain();
    // z85: one good group, then a ragged tail that ends in the error item
    write_reg(REG_Z85_VARIANT, 1'b1);
    push_byte(8'h86, 1'b0); push_byte(8'h4F, 1'b0);
    push_byte(8'hD2, 1'b0); push_byte(8'h6F, 1'b0);
    push_byte(8'hFF, 1'b1);
    // switch back to ascii85 with half a group held
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0);
    drain();
    write_reg(REG_Z85_VARIANT, 1'b0);
    push_byte(8'h56, 1'b0); push_byte(8'h78, 1'b1);

    run_phase(1'b0, 1'b0, 30, 8);
    run_phase(1'b0, 1'b1, 30, 8);
    run_phase(1'b1, 1'b1, 30, 8);
    // index past the register file must not touch either register
    drain();
    write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_SPACE_EN) + 1)),
              1'($urandom_range(1, 0)));
    queue_stream(12);
    run_phase(1'b1, 1'b0, 30, 8);
    run_phase(1'b0, 1'b1, 0, 24);

    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
